[src/lav_pkg.sv]
// Package for the look-at view matrix block: field widths, fixed-point formats
// and the internal widths shared by the normalizer, cross-product and top level.
// No dependencies.
`default_nettype none

package lav_pkg;

   // Port field formats
   localparam int IN_W    = 24;            // Q12.12 coordinates
   localparam int UNIT_W  = 16;            // Q1.14 unit components
   localparam int SHIFT_W = 26;            // Q14.12 translations

   // Internal vector widths
   localparam int FWD_W   = IN_W + 1;              // eye - target
   localparam int RGT_W   = IN_W + UNIT_W + 1;     // upward x forward
   localparam int CUP_W   = UNIT_W + RGT_W + 1;    // forward x right

   // Normalizer internals
   localparam int MANT_W  = 30;                    // scaled magnitude, max in [2^29, 2^30)
   localparam int RAD_W   = 2 * MANT_W + 2;        // sum of three squares
   localparam int ROOT_W  = RAD_W / 2;             // integer square root
   localparam int QUO_W   = UNIT_W;                // quotient bits before rounding

   // Translation internals
   localparam int TPROD_W = UNIT_W + IN_W;         // unit x eye product
   localparam int TSUM_W  = TPROD_W + 2;           // negated sum of three products

   localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(16384);

endpackage

`default_nettype wire

[src/lav_isqrt.sv]
// Pipelined integer square root, one result bit per register stage, with a
// sideband word carried alongside each item. Depends on lav_pkg.
`default_nettype none

module lav_isqrt #(
   parameter int SW = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [lav_pkg::RAD_W-1:0]   in_rad,
   input  wire logic [SW-1:0]               in_side,
   output logic                             out_valid,
   output logic [lav_pkg::ROOT_W-1:0]       out_root,
   output logic [SW-1:0]                    out_side
);

   localparam int N  = lav_pkg::ROOT_W;
   localparam int RW = lav_pkg::RAD_W;
   localparam int TW = RW + 2;

   logic          valid_ff [N];
   logic [RW-1:0] rem_ff   [N];
   logic [RW-1:0] rem_in   [N];
   logic [N-1:0]  root_ff  [N];
   logic [N-1:0]  root_in  [N];
   logic [SW-1:0] side_ff  [N];
   logic [RW-1:0] rem_src  [N];
   logic [N-1:0]  root_src [N];
   logic [TW-1:0] trial    [N];

   // Stage j settles root bit N-1-j: keep rem = n - root^2
   always_comb begin
      rem_src[0]  = in_rad;
      root_src[0] = '0;
      for (int j = 1; j < N; j++) begin
         rem_src[j]  = rem_ff[j-1];
         root_src[j] = root_ff[j-1];
      end
      for (int j = 0; j < N; j++) begin
         trial[j] = (TW'(root_src[j]) << (N - j)) | (TW'(1) << (2 * (N - 1 - j)));
         if (TW'(rem_src[j]) >= trial[j]) begin
            rem_in[j]  = rem_src[j] - trial[j][RW-1:0];
            root_in[j] = root_src[j] | (N'(1) << (N - 1 - j));
         end else begin
            rem_in[j]  = rem_src[j];
            root_in[j] = root_src[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < N; j++) valid_ff[j] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j < N; j++) valid_ff[j] <= valid_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int j = 1; j < N; j++) side_ff[j] <= side_ff[j-1];
         for (int j = 0; j < N; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

`default_nettype wire

[src/lav_norm.sv]
// Pipelined vector normalizer: scale magnitudes, sum of squares, square root,
// three restoring dividers and rounding to Q1.14. Depends on lav_pkg, lav_isqrt.
`default_nettype none

module lav_norm #(
   parameter int W  = lav_pkg::FWD_W,
   parameter int SW = 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               in_valid,
   input  wire logic signed [W-1:0]                in_vec [3],
   input  wire logic [SW-1:0]                      in_side,
   output logic                                    out_valid,
   output logic signed [lav_pkg::UNIT_W-1:0]       out_vec [3],
   output logic [SW-1:0]                           out_side
);

   localparam int MW = lav_pkg::MANT_W;
   localparam int RW = lav_pkg::RAD_W;
   localparam int LW = lav_pkg::ROOT_W;
   localparam int QW = lav_pkg::QUO_W;
   localparam int UW = lav_pkg::UNIT_W;
   localparam int AW = $clog2(W + MW);
   localparam int PW = SW + 4 + 3 * MW;
   localparam int CW = SW + 4 + LW;
   localparam int ND = QW;
   localparam int DW = LW + 1;

   function automatic logic [AW-1:0] msb_of(input logic [W-1:0] x);
      logic [AW-1:0] idx;
      idx = '0;
      for (int i = 0; i < W; i++) begin
         if (x[i]) idx = AW'(i);
      end
      return idx;
   endfunction

   // Stage 1: magnitudes and signs
   logic          v1_ff;
   logic [W-1:0]  mag1_ff [3];
   logic [W-1:0]  mag1_in [3];
   logic [2:0]    neg1_ff, neg1_in;
   logic [SW-1:0] side1_ff;

   // Stage 2: largest magnitude
   logic          v2_ff;
   logic [W-1:0]  mag2_ff [3];
   logic [W-1:0]  big2_ff, big2_in;
   logic [2:0]    neg2_ff;
   logic [SW-1:0] side2_ff;

   // Stage 3: common shift
   logic          v3_ff;
   logic [W-1:0]  mag3_ff [3];
   logic [AW-1:0] msb3;
   logic [AW-1:0] amt3_ff, amt3_in;
   logic          rsft3_ff, rsft3_in;
   logic          zero3_ff;
   logic [2:0]    neg3_ff;
   logic [SW-1:0] side3_ff;

   // Stage 4: scaled magnitudes
   logic            v4_ff;
   logic [W+MW-1:0] wide4 [3];
   logic [MW-1:0]   m4_ff [3];
   logic [MW-1:0]   m4_in [3];
   logic            zero4_ff;
   logic [2:0]      neg4_ff;
   logic [SW-1:0]   side4_ff;

   // Stage 5: squares
   logic            v5_ff;
   logic [2*MW-1:0] sq5_ff [3];
   logic [2*MW-1:0] sq5_in [3];
   logic [MW-1:0]   m5_ff [3];
   logic            zero5_ff;
   logic [2:0]      neg5_ff;
   logic [SW-1:0]   side5_ff;

   // Stage 6: sum of squares
   logic          v6_ff;
   logic [RW-1:0] rad6_ff, rad6_in;
   logic [PW-1:0] pk6_ff, pk6_in;

   // Square root outputs
   logic          vq;
   logic [LW-1:0] root_q;
   logic [PW-1:0] pk_q;

   // Divider stages
   logic          vd_ff  [ND];
   logic [DW-1:0] r_ff   [ND][3];
   logic [DW-1:0] r_in   [ND][3];
   logic [DW-1:0] r_src  [ND][3];
   logic [DW-1:0] dif    [ND][3];
   logic [QW-1:0] q_ff   [ND][3];
   logic [QW-1:0] q_in   [ND][3];
   logic [QW-1:0] q_src  [ND][3];
   logic [CW-1:0] cy_ff  [ND];
   logic [CW-1:0] cy_src [ND];

   // Final rounding stage
   logic                 vo_ff;
   logic signed [UW-1:0] out_ff [3];
   logic signed [UW-1:0] out_in [3];
   logic [SW-1:0]        sideo_ff;
   logic [QW:0]          qr [3];
   logic [QW-1:0]        qh [3];
   logic [CW-1:0]        cy_last;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][W-1];
         mag1_in[i] = neg1_in[i] ? (W'(0) - $unsigned(in_vec[i])) : $unsigned(in_vec[i]);
      end

      big2_in = mag1_ff[0];
      if (mag1_ff[1] > big2_in) big2_in = mag1_ff[1];
      if (mag1_ff[2] > big2_in) big2_in = mag1_ff[2];

      msb3 = msb_of(big2_ff);
      if (msb3 >= AW'(MW - 1)) begin
         rsft3_in = 1'b1;
         amt3_in  = msb3 - AW'(MW - 1);
      end else begin
         rsft3_in = 1'b0;
         amt3_in  = AW'(MW - 1) - msb3;
      end

      for (int i = 0; i < 3; i++) begin
         wide4[i] = (W + MW)'(mag3_ff[i]);
         wide4[i] = rsft3_ff ? (wide4[i] >> amt3_ff) : (wide4[i] << amt3_ff);
         m4_in[i] = wide4[i][MW-1:0];
         sq5_in[i] = m4_ff[i] * m4_ff[i];
      end

      rad6_in = RW'(sq5_ff[0]) + RW'(sq5_ff[1]) + RW'(sq5_ff[2]);
      pk6_in  = {side5_ff, neg5_ff, zero5_ff, m5_ff[2], m5_ff[1], m5_ff[0]};
   end

   // Restoring division m * 2^15 / L, one quotient bit per stage
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_src[0][i] = DW'(pk_q[i*MW +: MW]);
         q_src[0][i] = '0;
      end
      cy_src[0] = {pk_q[PW-1:3*MW], root_q};
      for (int j = 1; j < ND; j++) begin
         for (int i = 0; i < 3; i++) begin
            r_src[j][i] = r_ff[j-1][i];
            q_src[j][i] = q_ff[j-1][i];
         end
         cy_src[j] = cy_ff[j-1];
      end
      for (int j = 0; j < ND; j++) begin
         for (int i = 0; i < 3; i++) begin
            q_in[j][i] = q_src[j][i];
            dif[j][i]  = r_src[j][i];
            if (r_src[j][i] >= DW'(cy_src[j][LW-1:0])) begin
               dif[j][i] = r_src[j][i] - DW'(cy_src[j][LW-1:0]);
               q_in[j][i][ND-1-j] = 1'b1;
            end
            r_in[j][i] = {dif[j][i][LW-1:0], 1'b0};
         end
      end
   end

   // Round half away, cap at one, apply sign
   always_comb begin
      cy_last = cy_ff[ND-1];
      for (int i = 0; i < 3; i++) begin
         qr[i] = (QW + 1)'(q_ff[ND-1][i]) + (QW + 1)'(1);
         qh[i] = qr[i][QW:1];
         if (qh[i] > lav_pkg::UNIT_ONE) qh[i] = lav_pkg::UNIT_ONE;
         if (cy_last[LW]) begin
            out_in[i] = '0;
         end else if (cy_last[LW+1+i]) begin
            out_in[i] = $signed(UW'(0) - qh[i]);
         end else begin
            out_in[i] = $signed(qh[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         for (int j = 0; j < ND; j++) vd_ff[j] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         vd_ff[0] <= vq;
         for (int j = 1; j < ND; j++) vd_ff[j] <= vd_ff[j-1];
         vo_ff <= vd_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         side1_ff <= in_side;

         mag2_ff  <= mag1_ff;
         big2_ff  <= big2_in;
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;

         mag3_ff  <= mag2_ff;
         amt3_ff  <= amt3_in;
         rsft3_ff <= rsft3_in;
         zero3_ff <= (big2_ff == '0);
         neg3_ff  <= neg2_ff;
         side3_ff <= side2_ff;

         m4_ff    <= m4_in;
         zero4_ff <= zero3_ff;
         neg4_ff  <= neg3_ff;
         side4_ff <= side3_ff;

         sq5_ff   <= sq5_in;
         m5_ff    <= m4_ff;
         zero5_ff <= zero4_ff;
         neg5_ff  <= neg4_ff;
         side5_ff <= side4_ff;

         rad6_ff  <= rad6_in;
         pk6_ff   <= pk6_in;

         for (int j = 0; j < ND; j++) begin
            r_ff[j]  <= r_in[j];
            q_ff[j]  <= q_in[j];
            cy_ff[j] <= cy_src[j];
         end

         out_ff   <= out_in;
         sideo_ff <= cy_last[CW-1:LW+4];
      end
   end

   lav_isqrt #(
      .SW (PW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v6_ff),
      .in_rad    (rad6_ff),
      .in_side   (pk6_ff),
      .out_valid (vq),
      .out_root  (root_q),
      .out_side  (pk_q)
   );

   assign out_valid = vo_ff;
   assign out_vec   = out_ff;
   assign out_side  = sideo_ff;

endmodule

`default_nettype wire

[src/lav_cross.sv]
// Two-stage cross product a x b of signed integer vectors with a sideband word.
// Depends on lav_pkg.
`default_nettype none

module lav_cross #(
   parameter int AW = lav_pkg::IN_W,
   parameter int BW = lav_pkg::UNIT_W,
   parameter int SW = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire logic signed [AW-1:0]   in_a [3],
   input  wire logic signed [BW-1:0]   in_b [3],
   input  wire logic [SW-1:0]          in_side,
   output logic                        out_valid,
   output logic signed [AW+BW:0]       out_vec [3],
   output logic [SW-1:0]               out_side
);

   localparam int PW = AW + BW;

   logic                 v1_ff;
   logic signed [PW-1:0] prod_ff [6];
   logic signed [PW-1:0] prod_in [6];
   logic [SW-1:0]        side1_ff;
   logic                 v2_ff;
   logic signed [PW:0]   vec_ff [3];
   logic signed [PW:0]   vec_in [3];
   logic [SW-1:0]        side2_ff;

   always_comb begin
      prod_in[0] = in_a[1] * in_b[2];
      prod_in[1] = in_a[2] * in_b[1];
      prod_in[2] = in_a[2] * in_b[0];
      prod_in[3] = in_a[0] * in_b[2];
      prod_in[4] = in_a[0] * in_b[1];
      prod_in[5] = in_a[1] * in_b[0];
      for (int i = 0; i < 3; i++) begin
         vec_in[i] = (PW + 1)'(prod_ff[2*i]) - (PW + 1)'(prod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         side1_ff <= in_side;
         vec_ff   <= vec_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side2_ff;

endmodule

`default_nettype wire

[src/look_at_view_matrix.sv]
// Look-at view matrix top level: forward normalize, two cross products, right
// and up normalize, translations. Depends on lav_pkg, lav_norm, lav_cross.
//
// Throughput: one camera set per cycle unless a stalled response holds the
//   pipeline; every stage is a register and the square roots (31 stages)
//   and divisions (16 stages) are fully pipelined.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
`default_nettype none

module look_at_view_matrix (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_eye_x,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_eye_y,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_eye_z,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_target_x,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_target_y,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_target_z,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_upward_x,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_upward_y,
   input  wire logic signed [lav_pkg::IN_W-1:0]     req_upward_z,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_right_x,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_right_y,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_right_z,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_camup_x,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_camup_y,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_camup_z,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_back_x,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_back_y,
   output logic signed [lav_pkg::UNIT_W-1:0]        rsp_back_z,
   output logic signed [lav_pkg::SHIFT_W-1:0]       rsp_shift_right,
   output logic signed [lav_pkg::SHIFT_W-1:0]       rsp_shift_up,
   output logic signed [lav_pkg::SHIFT_W-1:0]       rsp_shift_back
);

   localparam int IW   = lav_pkg::IN_W;
   localparam int UW   = lav_pkg::UNIT_W;
   localparam int FW   = lav_pkg::FWD_W;
   localparam int RTW  = lav_pkg::RGT_W;
   localparam int CPW  = lav_pkg::CUP_W;
   localparam int SHW  = lav_pkg::SHIFT_W;
   localparam int PRW  = lav_pkg::TPROD_W;
   localparam int SMW  = lav_pkg::TSUM_W;
   localparam int MGW  = SMW - 14;

   // Sideband layouts
   localparam int EYE_SW = 3 * IW;
   localparam int FN_SW  = 3 * UW;
   localparam int F_SW   = 6 * IW;            // eye, upward
   localparam int C1_SW  = EYE_SW + FN_SW;    // eye, forward unit
   localparam int C2_SW  = C1_SW + 3 * RTW;   // eye, forward unit, right

   localparam logic [MGW-1:0] MAG_CAP = MGW'(1) << SHW;

   // Round to Q14.12 half away from zero, then saturate
   function automatic logic signed [SHW-1:0] round_shift(input logic signed [SMW-1:0] t);
      logic [SMW-1:0] mag;
      logic [SMW-1:0] sum;
      logic [MGW-1:0] m;
      logic [MGW-1:0] r;
      mag = t[SMW-1] ? (SMW'(0) - $unsigned(t)) : $unsigned(t);
      sum = mag + (SMW'(1) << 13);
      m   = sum[SMW-1:14];
      if (m > MAG_CAP) m = MAG_CAP;
      r = t[SMW-1] ? (MGW'(0) - m) : m;
      if (!t[SMW-1] && (m > MGW'((1 << (SHW - 1)) - 1))) begin
         return $signed({1'b0, {(SHW-1){1'b1}}});
      end else if (t[SMW-1] && (m > MGW'(1 << (SHW - 1)))) begin
         return $signed({1'b1, {(SHW-1){1'b0}}});
      end
      return $signed(r[SHW-1:0]);
   endfunction

   // Whole pipeline advances together; hold everything while the result
   // register is full and the consumer stalls.
   logic advance;
   logic t3_valid_ff;

   assign advance   = !(t3_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Forward vector and request sideband
   logic signed [IW-1:0] eye_in [3];
   logic signed [IW-1:0] up_in  [3];
   logic signed [IW-1:0] tgt_in [3];
   logic signed [FW-1:0] fwd    [3];
   logic [F_SW-1:0]      f_side_in;

   always_comb begin
      eye_in[0] = req_eye_x;
      eye_in[1] = req_eye_y;
      eye_in[2] = req_eye_z;
      tgt_in[0] = req_target_x;
      tgt_in[1] = req_target_y;
      tgt_in[2] = req_target_z;
      up_in[0]  = req_upward_x;
      up_in[1]  = req_upward_y;
      up_in[2]  = req_upward_z;
      for (int i = 0; i < 3; i++) begin
         fwd[i] = FW'(eye_in[i]) - FW'(tgt_in[i]);
         f_side_in[i*IW +: IW]          = eye_in[i];
         f_side_in[EYE_SW + i*IW +: IW] = up_in[i];
      end
   end

   // Normalize forward (eye - target)
   logic                 fn_valid;
   logic signed [UW-1:0] fn_vec [3];
   logic [F_SW-1:0]      fn_side;

   lav_norm #(
      .W  (FW),
      .SW (F_SW)
   ) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_vec    (fwd),
      .in_side   (f_side_in),
      .out_valid (fn_valid),
      .out_vec   (fn_vec),
      .out_side  (fn_side)
   );

   // Right = upward x forward unit
   logic signed [IW-1:0] up_f [3];
   logic [C1_SW-1:0]     c1_side_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         up_f[i] = $signed(fn_side[EYE_SW + i*IW +: IW]);
         c1_side_in[i*IW +: IW]          = fn_side[i*IW +: IW];
         c1_side_in[EYE_SW + i*UW +: UW] = fn_vec[i];
      end
   end

   logic                  r_valid;
   logic signed [RTW-1:0] r_vec [3];
   logic [C1_SW-1:0]      r_side;

   lav_cross #(
      .AW (IW),
      .BW (UW),
      .SW (C1_SW)
   ) u_cross_right (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fn_valid),
      .in_a      (up_f),
      .in_b      (fn_vec),
      .in_side   (c1_side_in),
      .out_valid (r_valid),
      .out_vec   (r_vec),
      .out_side  (r_side)
   );

   // True up = forward unit x unnormalized right
   logic signed [UW-1:0] fn_r [3];
   logic [C2_SW-1:0]     c2_side_in;

   always_comb begin
      c2_side_in[C1_SW-1:0] = r_side;
      for (int i = 0; i < 3; i++) begin
         fn_r[i] = $signed(r_side[EYE_SW + i*UW +: UW]);
         c2_side_in[C1_SW + i*RTW +: RTW] = r_vec[i];
      end
   end

   logic                  u_valid;
   logic signed [CPW-1:0] u_vec [3];
   logic [C2_SW-1:0]      u_side;

   lav_cross #(
      .AW (UW),
      .BW (RTW),
      .SW (C2_SW)
   ) u_cross_up (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (r_valid),
      .in_a      (fn_r),
      .in_b      (r_vec),
      .in_side   (c2_side_in),
      .out_valid (u_valid),
      .out_vec   (u_vec),
      .out_side  (u_side)
   );

   // Normalize right and true up side by side; right carries eye, up carries
   // the forward unit so both land together.
   logic signed [RTW-1:0] r_al [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_al[i] = $signed(u_side[C1_SW + i*RTW +: RTW]);
      end
   end

   logic                 rn_valid;
   logic signed [UW-1:0] rn_vec [3];
   logic [EYE_SW-1:0]    rn_side;
   logic                 un_valid;
   logic signed [UW-1:0] un_vec [3];
   logic [FN_SW-1:0]     un_side;

   lav_norm #(
      .W  (RTW),
      .SW (EYE_SW)
   ) u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (u_valid),
      .in_vec    (r_al),
      .in_side   (u_side[EYE_SW-1:0]),
      .out_valid (rn_valid),
      .out_vec   (rn_vec),
      .out_side  (rn_side)
   );

   lav_norm #(
      .W  (CPW),
      .SW (FN_SW)
   ) u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (u_valid),
      .in_vec    (u_vec),
      .in_side   (u_side[C1_SW-1:EYE_SW]),
      .out_valid (un_valid),
      .out_vec   (un_vec),
      .out_side  (un_side)
   );

   // Translation stage 1: unit x eye products. Row 0 right, 1 up, 2 back.
   logic signed [IW-1:0]  eye_t [3];
   logic signed [UW-1:0]  unit0 [3][3];
   logic                  t1_valid_ff;
   logic signed [PRW-1:0] prod1_ff [3][3];
   logic signed [PRW-1:0] prod1_in [3][3];
   logic signed [UW-1:0]  unit1_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_t[i]    = $signed(rn_side[i*IW +: IW]);
         unit0[0][i] = rn_vec[i];
         unit0[1][i] = un_vec[i];
         unit0[2][i] = $signed(un_side[i*UW +: UW]);
      end
      for (int t = 0; t < 3; t++) begin
         for (int i = 0; i < 3; i++) begin
            prod1_in[t][i] = unit0[t][i] * eye_t[i];
         end
      end
   end

   // Translation stage 2: negated sums
   logic                  t2_valid_ff;
   logic signed [SMW-1:0] sum2_ff [3];
   logic signed [SMW-1:0] sum2_in [3];
   logic signed [UW-1:0]  unit2_ff [3][3];

   always_comb begin
      for (int t = 0; t < 3; t++) begin
         sum2_in[t] = SMW'(0) - (SMW'(prod1_ff[t][0]) + SMW'(prod1_ff[t][1])
                                 + SMW'(prod1_ff[t][2]));
      end
   end

   // Translation stage 3: round and saturate into the result register
   logic signed [SHW-1:0] shift3_ff [3];
   logic signed [SHW-1:0] shift3_in [3];
   logic signed [UW-1:0]  unit3_ff [3][3];

   always_comb begin
      for (int t = 0; t < 3; t++) shift3_in[t] = round_shift(sum2_ff[t]);
   end

   // Both normalizers run in lockstep, so their valid bits always agree
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
      end else if (advance) begin
         t1_valid_ff <= rn_valid && un_valid;
         t2_valid_ff <= t1_valid_ff;
         t3_valid_ff <= t2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod1_ff  <= prod1_in;
         unit1_ff  <= unit0;
         sum2_ff   <= sum2_in;
         unit2_ff  <= unit1_ff;
         shift3_ff <= shift3_in;
         unit3_ff  <= unit2_ff;
      end
   end

   // Drive the response beat from the result register
   assign rsp_valid       = t3_valid_ff;
   assign rsp_right_x     = unit3_ff[0][0];
   assign rsp_right_y     = unit3_ff[0][1];
   assign rsp_right_z     = unit3_ff[0][2];
   assign rsp_camup_x     = unit3_ff[1][0];
   assign rsp_camup_y     = unit3_ff[1][1];
   assign rsp_camup_z     = unit3_ff[1][2];
   assign rsp_back_x      = unit3_ff[2][0];
   assign rsp_back_y      = unit3_ff[2][1];
   assign rsp_back_z      = unit3_ff[2][2];
   assign rsp_shift_right = shift3_ff[0];
   assign rsp_shift_up    = shift3_ff[1];
   assign rsp_shift_back  = shift3_ff[2];

endmodule

`default_nettype wire

[src/lav_checker.sv]
// Port-level checks for look_at_view_matrix, attached by the bind below.
// Depends on lav_pkg.
`default_nettype none

module lav_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_eye_x,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_eye_y,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_eye_z,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_target_x,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_target_y,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_target_z,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_upward_x,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_upward_y,
   input wire logic signed [lav_pkg::IN_W-1:0]     req_upward_z,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_right_x,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_right_y,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_right_z,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_camup_x,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_camup_y,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_camup_z,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_back_x,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_back_y,
   input wire logic signed [lav_pkg::UNIT_W-1:0]   rsp_back_z,
   input wire logic signed [lav_pkg::SHIFT_W-1:0]  rsp_shift_right,
   input wire logic signed [lav_pkg::SHIFT_W-1:0]  rsp_shift_up,
   input wire logic signed [lav_pkg::SHIFT_W-1:0]  rsp_shift_back
);

   // A stalled response beat stays valid and holds its translations and one component of each basis vector
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_right_x)
         && $stable(rsp_camup_y) && $stable(rsp_back_z) && $stable(rsp_shift_right)
         && $stable(rsp_shift_up) && $stable(rsp_shift_back))
      else $error("stalled response beat changed");

   // Request side stalls exactly when a finished result is held back
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow response stall");

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("response valid right after reset");

   // Eye on target: whole basis and all translations are zero
   a_zero_basis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_back_x == 0 && rsp_back_y == 0 && rsp_back_z == 0
      |-> rsp_right_x == 0 && rsp_right_y == 0 && rsp_right_z == 0
         && rsp_camup_x == 0 && rsp_camup_y == 0 && rsp_camup_z == 0
         && rsp_shift_right == 0 && rsp_shift_up == 0 && rsp_shift_back == 0)
      else $error("zero forward vector with nonzero basis");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);

`default_nettype wire
